FILE: hw/rtl/usr_pkg.sv
// shared types and constants for the ultrasonic ranger scheduler
// no dependencies; imported by usr_dist, usr_sched and the top level
package usr_pkg;

  localparam int unsigned SENSOR_COUNT = 3;

  localparam int unsigned MS_W   = 32;
  localparam int unsigned US_W   = 16;
  localparam int unsigned DIST_W = 9;
  localparam int unsigned CFGMS_W = 10;
  localparam int unsigned SENS_W = 2;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned REG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ECHO = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  // sensor codes
  localparam logic [SENS_W-1:0] SENS_LEFT    = 2'd0;
  localparam logic [SENS_W-1:0] SENS_CENTER  = 2'd1;
  localparam logic [SENS_W-1:0] SENS_RIGHT   = 2'd2;
  localparam logic [SENS_W-1:0] SENS_UNKNOWN = 2'd3;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_INTER_TRIGGER = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ECHO_TIMEOUT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_DISTANCE  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_DISTANCE  = 2'd3;

  // reset values
  localparam logic [CFGMS_W-1:0] INTER_TRIGGER_RST = 10'd60;
  localparam logic [CFGMS_W-1:0] ECHO_TIMEOUT_RST  = 10'd40;
  localparam logic [DIST_W-1:0]  MIN_DISTANCE_RST  = 9'd2;
  localparam logic [DIST_W-1:0]  MAX_DISTANCE_RST  = 9'd400;
  localparam logic [MS_W-1:0]    FIRST_TRIGGER_MS  = 32'd100;

  // distance = (pulse + 29) / 58 = ((pulse + 29) >> 1) / 29
  // x / 29 for x < 2^16 is (x * 72316) >> 21, exact over that range
  localparam logic [US_W:0]   PULSE_ROUND = 17'd29;
  localparam logic [16:0]     DIV29_RECIP = 17'd72316;
  localparam int unsigned     DIV29_SHIFT = 21;
  localparam int unsigned     RAW_DIST_W  = 12;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_RISE = 3'b010,
    PH_FALL = 3'b100
  } phase_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SENS_W-1:0] echo_sensor;
    logic              echo_high;
    logic [US_W-1:0]   timer_us;
    logic [SENS_W-1:0] read_sensor;
  } in_word_t;

  typedef struct packed {
    logic              trigger_fire;
    logic [SENS_W-1:0] trigger_sensor;
    logic              done_res;
    logic [SENS_W-1:0] done_sensor;
    logic [DIST_W-1:0] done_distance_cm;
    logic              done_timeout;
    logic [DIST_W-1:0] read_distance_cm;
    logic              read_valid;
    logic              read_timeout;
    logic [MS_W-1:0]   read_age_ms;
  } out_word_t;

  typedef struct packed {
    logic [CFGMS_W-1:0] inter_trigger_ms;
    logic [CFGMS_W-1:0] echo_timeout_ms;
    logic [DIST_W-1:0]  min_distance_cm;
    logic [DIST_W-1:0]  max_distance_cm;
  } cfg_t;

endpackage

FILE: hw/rtl/ultrasonic_ranger_scheduler_top.sv
// top level of the ultrasonic ranger scheduler: word registers and config
// depends on usr_pkg and usr_sched

// Schedules three echo-ranging sensors in the order center, right, center,
// left. Every input word (millisecond tick, echo edge or readout) gives one
// output word. A word goes into an input register, is processed combinationally
// by usr_sched (state update, pulse-to-distance via one reciprocal multiply)
// and lands in an output register; one word per cycle is sustained while the
// output is not stalled. A word waits in the input register until the output
// register is free or draining, and its result is then loaded there. The
// first trigger fires on the tick that brings time to 100 ms. Configuration
// registers take effect immediately and should be written while no word is
// in flight.
module ultrasonic_ranger_scheduler_top import usr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input words
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  // output words
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic      in_vld_q;
  in_word_t  in_q;
  logic      out_vld_q;
  out_word_t out_q;
  out_word_t res;
  cfg_t      cfg_q;
  logic      step;

  // process the held word when the output register is free or draining
  assign step       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !step;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_word_i;
    end
  end

  usr_sched u_sched (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .word_i (in_q),
    .cfg_i  (cfg_q),
    .word_o (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inter_trigger_ms <= INTER_TRIGGER_RST;
      cfg_q.echo_timeout_ms  <= ECHO_TIMEOUT_RST;
      cfg_q.min_distance_cm  <= MIN_DISTANCE_RST;
      cfg_q.max_distance_cm  <= MAX_DISTANCE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INTER_TRIGGER: cfg_q.inter_trigger_ms <= cfg_wdata_i;
        REG_ECHO_TIMEOUT:  cfg_q.echo_timeout_ms  <= cfg_wdata_i;
        REG_MIN_DISTANCE:  cfg_q.min_distance_cm  <= cfg_wdata_i[DIST_W-1:0];
        REG_MAX_DISTANCE:  cfg_q.max_distance_cm  <= cfg_wdata_i[DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // a stalled input only while a word is held
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q) else $error("input stalled with empty register");

  // a word never both fires a trigger and completes a measurement
  a_fire_xor_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.trigger_fire && out_q.done_res))
    else $error("trigger and completion in one word");

  // a completion always names a real sensor
  a_done_sensor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.done_res) |-> (out_q.done_sensor != SENS_UNKNOWN))
    else $error("completion on unknown sensor");

  // no reading means age all ones
  a_age_no_reading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.read_valid) |-> (out_q.read_age_ms == '1))
    else $error("age reported without reading");

  // a word that is processed shows up at the output next cycle
  a_step_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q) else $error("processed word lost");

endmodule

FILE: hw/rtl/usr_dist.sv
// echo pulse width to saturated distance in cm
// depends on usr_pkg
module usr_dist import usr_pkg::*; (
  input  logic [US_W-1:0]   timer_us_i,
  input  logic [US_W-1:0]   rise_us_i,
  input  logic [DIST_W-1:0] min_cm_i,
  input  logic [DIST_W-1:0] max_cm_i,
  output logic [DIST_W-1:0] dist_cm_o
);

  logic [US_W-1:0]       pulse;
  logic [US_W:0]         rounded;
  logic [US_W-1:0]       half;
  logic [32:0]           prod;
  logic [RAW_DIST_W-1:0] raw;

  always_comb begin
    pulse   = timer_us_i - rise_us_i;   // wraps mod 2^16
    rounded = {1'b0, pulse} + PULSE_ROUND;
    half    = rounded[US_W:1];
    prod    = 33'(half) * 33'(DIV29_RECIP);
    raw     = prod[DIV29_SHIFT +: RAW_DIST_W];
    priority if (raw < RAW_DIST_W'(min_cm_i)) begin
      dist_cm_o = min_cm_i;
    end else if (raw > RAW_DIST_W'(max_cm_i)) begin
      dist_cm_o = max_cm_i;
    end else begin
      dist_cm_o = raw[DIST_W-1:0];
    end
  end

endmodule

FILE: hw/rtl/usr_sched.sv
// trigger scheduling, echo timing and per-sensor reading store
// depends on usr_pkg and usr_dist
module usr_sched import usr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_word_t  word_i,
  input  cfg_t      cfg_i,
  output out_word_t word_o
);

  phase_e            phase_q, phase_d;
  logic [SENS_W-1:0] active_q, active_d;
  logic              side_left_q, side_left_d;
  logic [US_W-1:0]   rise_q, rise_d;
  logic [MS_W-1:0]   now_q, now_d;
  logic [MS_W-1:0]   trig_time_q, trig_time_d;
  logic [MS_W-1:0]   next_trig_q, next_trig_d;
  logic [DIST_W-1:0] dist_q [SENSOR_COUNT];
  logic [DIST_W-1:0] dist_d [SENSOR_COUNT];
  logic [MS_W-1:0]   upd_q  [SENSOR_COUNT];
  logic [MS_W-1:0]   upd_d  [SENSOR_COUNT];
  logic              has_q  [SENSOR_COUNT];
  logic              has_d  [SENSOR_COUNT];
  logic              to_q   [SENSOR_COUNT];
  logic              to_d   [SENSOR_COUNT];

  logic [DIST_W-1:0] echo_dist;
  logic [MS_W-1:0]   now_inc;
  logic [MS_W-1:0]   since_next;
  logic              fin;
  logic [DIST_W-1:0] fin_dist;
  logic              fin_to;

  usr_dist u_dist (
    .timer_us_i (word_i.timer_us),
    .rise_us_i  (rise_q),
    .min_cm_i   (cfg_i.min_distance_cm),
    .max_cm_i   (cfg_i.max_distance_cm),
    .dist_cm_o  (echo_dist)
  );

  always_comb begin
    phase_d     = phase_q;
    active_d    = active_q;
    side_left_d = side_left_q;
    rise_d      = rise_q;
    now_d       = now_q;
    trig_time_d = trig_time_q;
    next_trig_d = next_trig_q;
    dist_d      = dist_q;
    upd_d       = upd_q;
    has_d       = has_q;
    to_d        = to_q;
    word_o      = '0;
    fin         = 1'b0;
    fin_dist    = '0;
    fin_to      = 1'b0;
    now_inc     = now_q + 32'd1;
    since_next  = now_inc - next_trig_q;

    unique case (word_i.cmd)
      CMD_TICK: begin
        now_d = now_inc;
        if (phase_q == PH_IDLE) begin
          if (!since_next[MS_W-1]) begin
            trig_time_d = now_inc;
            next_trig_d = now_inc + MS_W'(cfg_i.inter_trigger_ms);
            phase_d     = PH_RISE;
            word_o.trigger_fire   = 1'b1;
            word_o.trigger_sensor = active_q;
          end
        end else if ((now_inc - trig_time_q) >= MS_W'(cfg_i.echo_timeout_ms)) begin
          fin      = 1'b1;
          fin_dist = cfg_i.max_distance_cm;
          fin_to   = 1'b1;
        end
      end
      CMD_ECHO: begin
        if (word_i.echo_sensor == active_q) begin
          if (phase_q == PH_RISE && word_i.echo_high) begin
            rise_d  = word_i.timer_us;
            phase_d = PH_FALL;
          end else if (phase_q == PH_FALL && !word_i.echo_high) begin
            fin      = 1'b1;
            fin_dist = echo_dist;
          end
        end
      end
      default: begin
        // readout only
      end
    endcase

    if (fin) begin
      dist_d[active_q] = fin_dist;
      upd_d[active_q]  = now_d;
      has_d[active_q]  = 1'b1;
      to_d[active_q]   = fin_to;
      word_o.done_res         = 1'b1;
      word_o.done_sensor      = active_q;
      word_o.done_distance_cm = fin_dist;
      word_o.done_timeout     = fin_to;
      phase_d = PH_IDLE;
      // center alternates right then left, a side always goes back to center
      if (active_q == SENS_CENTER) begin
        active_d    = side_left_q ? SENS_LEFT : SENS_RIGHT;
        side_left_d = !side_left_q;
      end else begin
        active_d = SENS_CENTER;
      end
    end

    // readout sees this word's update
    if (word_i.read_sensor != SENS_UNKNOWN) begin
      word_o.read_distance_cm = dist_d[word_i.read_sensor];
      word_o.read_valid       = has_d[word_i.read_sensor];
      word_o.read_timeout     = to_d[word_i.read_sensor];
      word_o.read_age_ms      = has_d[word_i.read_sensor]
                              ? now_d - upd_d[word_i.read_sensor] : '1;
    end else begin
      word_o.read_distance_cm = cfg_i.max_distance_cm;
      word_o.read_age_ms      = '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      active_q    <= SENS_CENTER;
      side_left_q <= 1'b0;
      rise_q      <= '0;
      now_q       <= '0;
      trig_time_q <= '0;
      next_trig_q <= FIRST_TRIGGER_MS;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        dist_q[i] <= MAX_DISTANCE_RST;
        upd_q[i]  <= '0;
        has_q[i]  <= 1'b0;
        to_q[i]   <= 1'b0;
      end
    end else if (step_i) begin
      phase_q     <= phase_d;
      active_q    <= active_d;
      side_left_q <= side_left_d;
      rise_q      <= rise_d;
      now_q       <= now_d;
      trig_time_q <= trig_time_d;
      next_trig_q <= next_trig_d;
      dist_q      <= dist_d;
      upd_q       <= upd_d;
      has_q       <= has_d;
      to_q        <= to_d;
    end
  end

endmodule

FILE: tb/ultrasonic_ranger_scheduler_top_test.sv
// self-checking testbench for ultrasonic_ranger_scheduler_top: directed words, then random
// words that mostly follow the ranging cycle across register settings; depends on usr_pkg and the rtl
`timescale 1ns / 1ps

module ultrasonic_ranger_scheduler_top_test;
  import usr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  // echo pulse conversion: cm = (us + round) / us_per_cm
  localparam int unsigned ECHO_ROUND_US = 29;
  localparam int unsigned US_PER_CM = 58;
  // spare command code, handled as readout only
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int unsigned PHASES = 6;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_word = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;
  logic                  cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  ultrasonic_ranger_scheduler_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // scheduler prediction: own copy of registers, ranging state and readings
  // ---------------------------------------------------------------------------
  cfg_t              regs;
  phase_e            cur_phase;
  logic [SENS_W-1:0] aim_sensor;     // sensor being ranged or next to fire
  logic              left_turn;      // center is followed by left next time
  logic [US_W-1:0]   rise_stamp_us;
  logic [MS_W-1:0]   clock_ms;
  logic [MS_W-1:0]   fired_at_ms;
  logic [MS_W-1:0]   due_at_ms;
  logic [DIST_W-1:0] range_cm [SENSOR_COUNT];
  logic [MS_W-1:0]   stamp_ms [SENSOR_COUNT];
  logic              seen [SENSOR_COUNT];
  logic              lost [SENSOR_COUNT];

  int unsigned n_fire, n_ranged, n_timeout, n_words, n_errors;
  out_word_t   pending_q [$];
  int unsigned send_idle_pct, recv_stall_pct;
  int unsigned cycles;

  task automatic ranger_reset();
    regs.inter_trigger_ms = INTER_TRIGGER_RST;
    regs.echo_timeout_ms  = ECHO_TIMEOUT_RST;
    regs.min_distance_cm  = MIN_DISTANCE_RST;
    regs.max_distance_cm  = MAX_DISTANCE_RST;
    cur_phase     = PH_IDLE;
    aim_sensor    = SENS_CENTER;
    left_turn     = 1'b0;
    rise_stamp_us = '0;
    clock_ms      = '0;
    fired_at_ms   = '0;
    due_at_ms     = FIRST_TRIGGER_MS;
    for (int s = 0; s < SENSOR_COUNT; s++) begin
      range_cm[s] = MAX_DISTANCE_RST;
      stamp_ms[s] = '0;
      seen[s]     = 1'b0;
      lost[s]     = 1'b0;
    end
  endtask

  // store a finished measurement and move on in the center-right-center-left order
  task automatic ranger_complete(input logic [DIST_W-1:0] range_val, input logic to,
                                 inout out_word_t o);
    range_cm[aim_sensor] = range_val;
    stamp_ms[aim_sensor] = clock_ms;
    seen[aim_sensor]     = 1'b1;
    lost[aim_sensor]     = to;
    o.done_res         = 1'b1;
    o.done_sensor      = aim_sensor;
    o.done_distance_cm = range_val;
    o.done_timeout     = to;
    cur_phase = PH_IDLE;
    if (aim_sensor == SENS_CENTER) begin
      aim_sensor = left_turn ? SENS_LEFT : SENS_RIGHT;
      left_turn  = ~left_turn;
    end else begin
      aim_sensor = SENS_CENTER;
    end
  endtask

  // one input word in, one expected output word out; acted is low for ignored echoes
  task automatic ranger_predict(input in_word_t w, output out_word_t o, output bit acted);
    logic [MS_W-1:0] gap;
    logic [US_W-1:0] pulse;
    int unsigned     cm;
    o = '0;
    acted = 1'b1;
    case (w.cmd)
      CMD_TICK: begin
        clock_ms = clock_ms + 1;
        if (cur_phase == PH_IDLE) begin
          // trigger due once the signed distance to the due time is not negative
          gap = clock_ms - due_at_ms;
          if (!gap[MS_W-1]) begin
            fired_at_ms = clock_ms;
            due_at_ms   = clock_ms + MS_W'(regs.inter_trigger_ms);
            cur_phase   = PH_RISE;
            o.trigger_fire   = 1'b1;
            o.trigger_sensor = aim_sensor;
            n_fire++;
          end
        end else begin
          gap = clock_ms - fired_at_ms;
          if (gap >= MS_W'(regs.echo_timeout_ms)) begin
            ranger_complete(regs.max_distance_cm, 1'b1, o);
            n_timeout++;
          end
        end
      end
      CMD_ECHO: begin
        acted = 1'b0;
        if (w.echo_sensor == aim_sensor) begin
          if (cur_phase == PH_RISE && w.echo_high) begin
            rise_stamp_us = w.timer_us;
            cur_phase     = PH_FALL;
            acted         = 1'b1;
          end else if (cur_phase == PH_FALL && !w.echo_high) begin
            pulse = w.timer_us - rise_stamp_us;
            cm = (int'(pulse) + ECHO_ROUND_US) / US_PER_CM;
            // when the limits cross, a value below the lower limit takes it and any other the upper
            if (cm < regs.min_distance_cm) cm = regs.min_distance_cm;
            else if (cm > regs.max_distance_cm) cm = regs.max_distance_cm;
            ranger_complete(DIST_W'(cm), 1'b0, o);
            acted = 1'b1;
            n_ranged++;
          end
        end
      end
      default: ;
    endcase
    // readout reflects this word's update
    if (w.read_sensor != SENS_UNKNOWN) begin
      o.read_distance_cm = range_cm[w.read_sensor];
      o.read_valid       = seen[w.read_sensor];
      o.read_timeout     = lost[w.read_sensor];
      o.read_age_ms      = seen[w.read_sensor] ? clock_ms - stamp_ms[w.read_sensor] : '1;
    end else begin
      o.read_distance_cm = regs.max_distance_cm;
      o.read_age_ms      = '1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // word builders
  // ---------------------------------------------------------------------------
  function automatic in_word_t in_w(logic [CMD_W-1:0] cmd, logic [SENS_W-1:0] es,
                                    logic lvl, logic [US_W-1:0] tus,
                                    logic [SENS_W-1:0] rs);
    in_word_t w;
    w.cmd = cmd; w.echo_sensor = es; w.echo_high = lvl; w.timer_us = tus;
    w.read_sensor = rs;
    return w;
  endfunction

  function automatic out_word_t out_w(logic fire, logic [SENS_W-1:0] fs, logic dn,
                                      logic [SENS_W-1:0] ds, logic [DIST_W-1:0] dd,
                                      logic dto, logic [DIST_W-1:0] rd, logic rv,
                                      logic rt, logic [MS_W-1:0] age);
    out_word_t o;
    o.trigger_fire = fire; o.trigger_sensor = fs;
    o.done_res = dn; o.done_sensor = ds; o.done_distance_cm = dd; o.done_timeout = dto;
    o.read_distance_cm = rd; o.read_valid = rv; o.read_timeout = rt; o.read_age_ms = age;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // input side: random gaps before each word, hold until the block takes it
  // ---------------------------------------------------------------------------
  task automatic send_word(input in_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // predict, queue the expected word (typed one if given), then drive
  task automatic issue(input in_word_t w, input bit typed, input out_word_t typed_res);
    out_word_t o;
    bit        acted;
    ranger_predict(w, o, acted);
    pending_q.push_back(typed ? typed_res : o);
    if (acted) n_words++;
    send_word(w);
  endtask

  // random word that mostly follows the ranging cycle of the active sensor
  task automatic pick_word(output in_word_t w);
    int unsigned roll;
    logic [US_W-1:0] pulse;
    w = in_w(logic'($urandom_range(0, 1)) ? CMD_READ : CMD_SPARE,
             SENS_W'($urandom_range(0, 3)), logic'($urandom_range(0, 1)),
             US_W'($urandom()), SENS_W'($urandom_range(0, 3)));
    roll = $urandom_range(0, 99);
    if (cur_phase == PH_IDLE) begin
      // nothing to echo: mostly time passing toward the next trigger
      if (roll < 60) w.cmd = CMD_TICK;
      else if (roll >= 75) w.cmd = CMD_ECHO;
    end else if (roll < 45) begin
      w.cmd         = CMD_ECHO;
      w.echo_sensor = aim_sensor;
      w.echo_high   = (cur_phase == PH_RISE);
      if (cur_phase == PH_FALL) begin
        // mostly in-range pulses, now and then any length including wrap
        pulse = ($urandom_range(0, 7) == 0) ? US_W'($urandom()) :
                                              US_W'($urandom_range(0, 26000));
        w.timer_us = rise_stamp_us + pulse;
      end
    end else if (roll < 70) begin
      w.cmd = CMD_TICK;
    end else if (roll >= 80) begin
      w.cmd = CMD_ECHO;
    end
  endtask

  // ---------------------------------------------------------------------------
  // register writes, only with nothing in flight
  // ---------------------------------------------------------------------------
  task automatic cfg_put(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= d;
    @(posedge clk);
  endtask

  task automatic cfg_apply(input cfg_t c);
    cfg_put(REG_INTER_TRIGGER, c.inter_trigger_ms);
    cfg_put(REG_ECHO_TIMEOUT, c.echo_timeout_ms);
    cfg_put(REG_MIN_DISTANCE, CFG_DATA_W'(c.min_distance_cm));
    cfg_put(REG_MAX_DISTANCE, CFG_DATA_W'(c.max_distance_cm));
    cfg_we <= 1'b0;
    regs = c;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stall, compare each accepted word with the oldest one due
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [MS_W-1:0] e,
                             input logic [MS_W-1:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
      n_errors++;
    end
  endtask

  task automatic check_word(input out_word_t e, input out_word_t a);
    check_field("trigger_fire", e.trigger_fire, a.trigger_fire);
    check_field("trigger_sensor", e.trigger_sensor, a.trigger_sensor);
    check_field("done_res", e.done_res, a.done_res);
    check_field("done_sensor", e.done_sensor, a.done_sensor);
    check_field("done_distance_cm", e.done_distance_cm, a.done_distance_cm);
    check_field("done_timeout", e.done_timeout, a.done_timeout);
    check_field("read_distance_cm", e.read_distance_cm, a.read_distance_cm);
    check_field("read_valid", e.read_valid, a.read_valid);
    check_field("read_timeout", e.read_timeout, a.read_timeout);
    check_field("read_age_ms", e.read_age_ms, a.read_age_ms);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          $display("%0t: output word mismatch, expected none, got %p", $time, out_word);
          n_errors++;
        end else begin
          check_word(pending_q.pop_front(), out_word);
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  initial begin
    cycles = 0;
    wait (cycles >= CYCLE_LIMIT);
    $display("ultrasonic_ranger_scheduler_top regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // directed table: one row per word, reps repeats it, typed rows carry the
  // expected word, the rest go through the predictor
  // ---------------------------------------------------------------------------
  typedef struct {
    in_word_t    w;
    int unsigned reps;
    bit          typed;
    out_word_t   res;
  } plan_row_t;

  plan_row_t plan [$];

  task automatic add_row(input in_word_t w, input int unsigned reps, input bit typed,
                         input out_word_t res);
    plan_row_t r;
    r.w = w; r.reps = reps; r.typed = typed; r.res = res;
    plan.push_back(r);
  endtask

  initial begin
    cfg_t        setting [PHASES];
    int unsigned target [PHASES];
    int unsigned count;
    in_word_t    w;

    n_fire = 0; n_ranged = 0; n_timeout = 0; n_words = 0; n_errors = 0;
    send_idle_pct = 32;
    recv_stall_pct = 55;
    ranger_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // readouts with no reading, the invalid sensor and the spare command
    add_row(in_w(CMD_READ, SENS_LEFT, 1'b0, 16'h0, SENS_LEFT), 1, 1'b1,
            out_w(0, 0, 0, 0, 0, 0, 9'd400, 0, 0, '1));
    add_row(in_w(CMD_READ, SENS_LEFT, 1'b0, 16'h0, SENS_UNKNOWN), 1, 1'b1,
            out_w(0, 0, 0, 0, 0, 0, 9'd400, 0, 0, '1));
    add_row(in_w(CMD_SPARE, SENS_CENTER, 1'b1, 16'hFFFF, SENS_RIGHT), 1, 1'b1,
            out_w(0, 0, 0, 0, 0, 0, 9'd400, 0, 0, '1));
    // echo while idle goes nowhere
    add_row(in_w(CMD_ECHO, SENS_CENTER, 1'b1, 16'h1234, SENS_CENTER), 1, 1'b1,
            out_w(0, 0, 0, 0, 0, 0, 9'd400, 0, 0, '1));
    // run up to the first trigger at 100 ms
    add_row(in_w(CMD_TICK, SENS_LEFT, 1'b0, 16'h0, SENS_LEFT), 99, 1'b0, '0);
    add_row(in_w(CMD_TICK, SENS_LEFT, 1'b0, 16'h0, SENS_CENTER), 1, 1'b1,
            out_w(1, SENS_CENTER, 0, 0, 0, 0, 9'd400, 0, 0, '1));
    // unknown sensor and wrong level are ignored
    add_row(in_w(CMD_ECHO, SENS_UNKNOWN, 1'b1, 16'h0100, SENS_CENTER), 1, 1'b0, '0);
    add_row(in_w(CMD_ECHO, SENS_CENTER, 1'b0, 16'h0100, SENS_CENTER), 1, 1'b0, '0);
    // timer wrap between rise and fall, short pulse clipped to min
    add_row(in_w(CMD_ECHO, SENS_CENTER, 1'b1, 16'hFFF0, SENS_CENTER), 1, 1'b0, '0);
    add_row(in_w(CMD_ECHO, SENS_CENTER, 1'b0, 16'h0010, SENS_CENTER), 1, 1'b1,
            out_w(0, 0, 1, SENS_CENTER, 9'd2, 0, 9'd2, 1, 0, 32'd0));
    // right sensor, longest pulse clipped to max
    add_row(in_w(CMD_TICK, SENS_LEFT, 1'b0, 16'h0, SENS_RIGHT), 59, 1'b0, '0);
    add_row(in_w(CMD_TICK, SENS_LEFT, 1'b0, 16'h0, SENS_RIGHT), 1, 1'b1,
            out_w(1, SENS_RIGHT, 0, 0, 0, 0, 9'd400, 0, 0, '1));
    add_row(in_w(CMD_ECHO, SENS_RIGHT, 1'b1, 16'h0000, SENS_RIGHT), 1, 1'b0, '0);
    add_row(in_w(CMD_ECHO, SENS_RIGHT, 1'b0, 16'hFFFF, SENS_RIGHT), 1, 1'b1,
            out_w(0, 0, 1, SENS_RIGHT, 9'd400, 0, 9'd400, 1, 0, 32'd0));
    // back to center, exact 100 cm
    add_row(in_w(CMD_TICK, SENS_LEFT, 1'b0, 16'h0, SENS_CENTER), 60, 1'b0, '0);
    add_row(in_w(CMD_ECHO, SENS_CENTER, 1'b1, 16'd1000, SENS_CENTER), 1, 1'b0, '0);
    add_row(in_w(CMD_ECHO, SENS_CENTER, 1'b0, 16'd6771, SENS_CENTER), 1, 1'b1,
            out_w(0, 0, 1, SENS_CENTER, 9'd100, 0, 9'd100, 1, 0, 32'd0));
    // left sensor gets no echo and times out on the 40th ms
    add_row(in_w(CMD_TICK, SENS_LEFT, 1'b0, 16'h0, SENS_LEFT), 59, 1'b0, '0);
    add_row(in_w(CMD_TICK, SENS_LEFT, 1'b0, 16'h0, SENS_LEFT), 1, 1'b1,
            out_w(1, SENS_LEFT, 0, 0, 0, 0, 9'd400, 0, 0, '1));
    add_row(in_w(CMD_TICK, SENS_LEFT, 1'b0, 16'h0, SENS_LEFT), 39, 1'b0, '0);
    add_row(in_w(CMD_TICK, SENS_LEFT, 1'b0, 16'h0, SENS_LEFT), 1, 1'b1,
            out_w(0, 0, 1, SENS_LEFT, 9'd400, 1, 9'd400, 1, 1, 32'd0));
    // age of the center reading 100 ms on
    add_row(in_w(CMD_READ, SENS_RIGHT, 1'b1, 16'h0, SENS_CENTER), 1, 1'b1,
            out_w(0, 0, 0, 0, 0, 0, 9'd100, 1, 0, 32'd100));
    add_row(in_w(CMD_ECHO, SENS_LEFT, 1'b0, 16'h5555, SENS_LEFT), 1, 1'b0, '0);

    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) issue(plan[i].w, plan[i].typed, plan[i].res);
    end

    // register settings per random phase; the first keeps the reset values
    setting[0] = '{INTER_TRIGGER_RST, ECHO_TIMEOUT_RST, MIN_DISTANCE_RST, MAX_DISTANCE_RST};
    setting[1] = '{10'd1, 10'd1, 9'd0, 9'd0};
    setting[2] = '{10'd1000, 10'd1000, 9'd511, 9'd511};
    setting[3] = '{10'd5, 10'd30, 9'd2, 9'd400};
    setting[4] = '{10'd3, 10'd12, 9'd300, 9'd100};   // limits crossed
    setting[5] = '{CFGMS_W'($urandom_range(1, 20)), CFGMS_W'($urandom_range(1, 40)),
                   DIST_W'($urandom_range(0, 511)), DIST_W'($urandom_range(0, 511))};
    target = '{190, 185, 180, 185, 190, 186};

    for (int p = 0; p < PHASES; p++) begin
      // receiver-heavy stalls, then sender-heavy gaps, then full rate
      send_idle_pct  = (p < 2) ? 32 : (p < 4) ? 55 : 0;
      recv_stall_pct = (p < 2) ? 55 : (p < 4) ? 32 : 0;
      if (p != 0) begin
        drain();
        cfg_apply(setting[p]);
      end
      count = 0;
      while (count < target[p]) begin
        pick_word(w);
        issue(w, 1'b0, '0);
        count++;
      end
    end

    drain();
    $display("covered %0d words over %0d register settings and three gap patterns",
             n_words, PHASES);
    $display("%0d triggers, %0d echo ranges, %0d timeouts, %0d mismatches",
             n_fire, n_ranged, n_timeout, n_errors);
    if (n_errors == 0) begin
      $display("ultrasonic_ranger_scheduler_top regression: pass");
    end else begin
      $display("ultrasonic_ranger_scheduler_top regression: fail");
    end
    $finish;
  end

endmodule
